// ===== rtl/aoc_pkg.sv =====
`default_nettype none

package aoc_pkg;

  // Divider datapath widths: dividend 2*N + d fits 25 bits, divisor 2*d fits 18 bits
  localparam int unsigned DVD_W = 25;
  localparam int unsigned DVS_W = 18;
  localparam int unsigned Q_W   = 8;

  // Number of restoring steps, one quotient bit each
  localparam int unsigned DIV_STEPS = Q_W;

  // Rounded alpha = floor((2*D + 255) / 510)
  localparam logic [DVS_W-1:0] ALPHA_DIVISOR = 18'd510;
  localparam logic [7:0]       FULL_SCALE    = 8'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } state_t;

  // Control from the sequencer to each divider lane
  typedef struct packed {
    logic start;
    logic step;
  } div_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/alpha_over_compositor_unit.sv =====
// An accepted pixel pair is captured, then passes the product stage, the sum
//   stage, the 8-step bit-serial dividers (four lanes run in parallel) and
//   the done state, which loads the output register once it is free.
// A new pixel is taken while the previous result still waits at the output.
// Reset (rst, synchronous, active high) empties the output register, returns
//   the sequencer to idle and clears the visibility flag.
`default_nettype none

module alpha_over_compositor_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // base_red, base_green, base_blue, base_opacity, over_red, over_green,
  // over_blue, over_alpha
  input  wire logic [63:0] s_tdata,
  input  wire logic        s_tlast,   // end_of_image
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic      [31:0] m_tdata,
  output logic             m_tlast,   // image_done
  output logic             m_tuser    // any_visible
);

  aoc_pkg::state_t   state, state_next;
  aoc_pkg::div_ctl_t ctl;
  logic              load_out;
  logic [2:0]        cnt;
  logic              seen;

  // captured pixel pair
  logic [7:0]  bc [3];
  logic [7:0]  ba;
  logic [7:0]  oc [3];
  logic [7:0]  oa;
  logic        last;

  // product stage
  logic [15:0] pov [3];
  logic [15:0] pbs [3];
  logic [7:0]  wa;
  logic [16:0] dsum;

  logic [7:0]  wa_c;
  logic [15:0] bw_c;

  // divider operands and results
  logic [aoc_pkg::DVD_W-1:0] dvd [4];
  logic [aoc_pkg::DVS_W-1:0] dvs [4];
  logic [aoc_pkg::Q_W-1:0]   quo [4];

  logic dz;
  logic a_nz;

  // input request capture
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      bc[0] <= s_tdata[7:0];
      bc[1] <= s_tdata[15:8];
      bc[2] <= s_tdata[23:16];
      ba    <= s_tdata[31:24];
      oc[0] <= s_tdata[39:32];
      oc[1] <= s_tdata[47:40];
      oc[2] <= s_tdata[55:48];
      oa    <= s_tdata[63:56];
      last  <= s_tlast;
    end
  end

  // weights: D = oa*255 + ba*(255-oa)
  assign wa_c = aoc_pkg::FULL_SCALE - oa;
  assign bw_c = {8'b0, ba} * {8'b0, wa_c};

  always_ff @(posedge clk) begin
    if (state == aoc_pkg::ST_MUL) begin
      for (int c = 0; c < 3; c++) begin
        pov[c] <= {8'b0, oc[c]} * {8'b0, oa};
        pbs[c] <= {8'b0, bc[c]} * {8'b0, ba};
      end
      wa   <= wa_c;
      dsum <= {1'b0, oa, 8'b0} - {9'b0, oa} + {1'b0, bw_c};
    end
  end

  // divider operands: colors use (2N + D) / 2D, alpha uses (2D + 255) / 510
  always_comb begin
    logic [23:0] num;
    for (int c = 0; c < 3; c++) begin
      num    = ({pov[c], 8'b0} - {8'b0, pov[c]}) + {8'b0, pbs[c]} * {16'b0, wa};
      dvd[c] = {num, 1'b0} + {8'b0, dsum};
      dvs[c] = {dsum, 1'b0};
    end
    dvd[3] = {7'b0, dsum, 1'b0} + {17'b0, aoc_pkg::FULL_SCALE};
    dvs[3] = aoc_pkg::ALPHA_DIVISOR;
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    aoc_div_lane u_lane (
      .clk      (clk),
      .ctl      (ctl),
      .dividend (dvd[g]),
      .divisor  (dvs[g]),
      .quotient (quo[g])
    );
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aoc_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == aoc_pkg::ST_DIV) begin
        cnt <= cnt + 3'd1;
      end else begin
        cnt <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    load_out   = 1'b0;
    s_tready   = 1'b0;
    case (state)
      aoc_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = aoc_pkg::ST_MUL;
        end
      end
      aoc_pkg::ST_MUL: begin
        state_next = aoc_pkg::ST_SUM;
      end
      aoc_pkg::ST_SUM: begin
        ctl.start  = 1'b1;
        state_next = aoc_pkg::ST_DIV;
      end
      aoc_pkg::ST_DIV: begin
        ctl.step = 1'b1;
        if (cnt == 3'(aoc_pkg::DIV_STEPS - 1)) begin
          state_next = aoc_pkg::ST_DONE;
        end
      end
      aoc_pkg::ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = aoc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = aoc_pkg::ST_IDLE;
      end
    endcase
  end

  // fully transparent pair forces every byte to zero
  assign dz   = (dsum == 17'd0);
  assign a_nz = !dz && (quo[3] != 8'd0);

  // output register and visibility flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      seen     <= 1'b0;
    end else begin
      if (load_out) begin
        m_tvalid <= 1'b1;
        if (last) begin
          seen <= 1'b0;
        end else if (a_nz) begin
          seen <= 1'b1;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= dz ? 32'd0 : {quo[3], quo[2], quo[1], quo[0]};
      m_tlast <= last;
      m_tuser <= last && (seen || a_nz);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/aoc_div_lane.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle while ctl.step is high, MSB first.
// The quotient is known to fit Q_W bits.
module aoc_div_lane (
  input  wire logic                       clk,
  input  wire aoc_pkg::div_ctl_t          ctl,
  input  wire logic [aoc_pkg::DVD_W-1:0]  dividend,
  input  wire logic [aoc_pkg::DVS_W-1:0]  divisor,
  output logic      [aoc_pkg::Q_W-1:0]    quotient
);

  logic [aoc_pkg::DVD_W-1:0] rem;
  logic [aoc_pkg::DVD_W-1:0] dsh;
  logic [aoc_pkg::DVD_W:0]   diff;

  // trial subtract of the aligned divisor
  assign diff = {1'b0, rem} - {1'b0, dsh};

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem      <= dividend;
      dsh      <= {divisor, {(aoc_pkg::Q_W-1){1'b0}}};
      quotient <= '0;
    end else if (ctl.step) begin
      if (!diff[aoc_pkg::DVD_W]) begin
        rem      <= diff[aoc_pkg::DVD_W-1:0];
        quotient <= {quotient[aoc_pkg::Q_W-2:0], 1'b1};
      end else begin
        quotient <= {quotient[aoc_pkg::Q_W-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/aoc_checker.sv =====
`default_nettype none

module aoc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic        m_tlast,
  input wire logic        m_tuser
);

  // a result offered and not taken stays offered
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // reset empties the output side
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // one pixel in flight: no second request right after one is taken
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while busy");

  // visibility is only reported on the last pixel of an image
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("visibility flag outside image end");

  // zero alpha only arises from a fully transparent pair
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[31:24] == 8'd0) |-> (m_tdata[23:0] == 24'd0))
    else $error("color without coverage");

endmodule

bind alpha_over_compositor_unit aoc_checker u_aoc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== bench/tb_alpha_over_compositor_unit.sv =====
`timescale 1ns / 1ps

// Pixel pair as packed on s_tdata, base_red in the lowest byte
typedef struct packed {
  logic [7:0] over_alpha;
  logic [7:0] over_blue;
  logic [7:0] over_green;
  logic [7:0] over_red;
  logic [7:0] base_opacity;
  logic [7:0] base_blue;
  logic [7:0] base_green;
  logic [7:0] base_red;
} pixel_pair_t;

// Composite as seen on the output side: {tuser, tlast, tdata}
typedef struct packed {
  logic       visible;
  logic       done;
  logic [7:0] alpha;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
} composite_t;

class composite_scoreboard;
  composite_t  expected_q[$];
  bit          seen_visible;
  int          errors;
  int          pixels;
  int          results;
  int          transparent;
  int          images;
  int          dark_images;

  // round(num / den) half away from zero, all operands non-negative
  function int unsigned div_round(int unsigned num, int unsigned den);
    int unsigned q;
    q = (2 * num + den) / (2 * den);
    return (q > 255) ? 255 : q;
  endfunction

  function logic [7:0] blend(int unsigned bc, int unsigned ba, int unsigned oc,
                             int unsigned oa, int unsigned weight);
    return div_round(oc * oa * 255 + bc * ba * (255 - oa), weight);
  endfunction

  // Work out the composite of an accepted request and queue it
  function void note_request(pixel_pair_t p, logic last);
    composite_t  c;
    int unsigned weight;
    c = '0;
    weight = p.over_alpha * 255 + p.base_opacity * (255 - p.over_alpha);
    if (weight != 0) begin
      c.red   = blend(p.base_red, p.base_opacity, p.over_red, p.over_alpha, weight);
      c.green = blend(p.base_green, p.base_opacity, p.over_green, p.over_alpha, weight);
      c.blue  = blend(p.base_blue, p.base_opacity, p.over_blue, p.over_alpha, weight);
      c.alpha = div_round(weight, 255);
    end else begin
      transparent++;
    end
    if (c.alpha != 0) seen_visible = 1'b1;
    c.done = last;
    if (last) begin
      c.visible = seen_visible;
      images++;
      if (!seen_visible) dark_images++;
      seen_visible = 1'b0;
    end
    pixels++;
    expected_q.push_back(c);
  endfunction

  task report(string what, int got, int want);
    errors++;
    $display("[%0t] result %0d %s: got %0d, expected %0d", $time, results, what, got, want);
  endtask

  task check_result(logic [31:0] data, logic done, logic vis);
    composite_t got;
    composite_t want;
    got = {vis, done, data};
    results++;
    if (expected_q.size() == 0) begin
      report("arrived with no request pending, data", data, 0);
      return;
    end
    want = expected_q.pop_front();
    if (got.red != want.red) report("red", got.red, want.red);
    if (got.green != want.green) report("green", got.green, want.green);
    if (got.blue != want.blue) report("blue", got.blue, want.blue);
    if (got.alpha != want.alpha) report("alpha", got.alpha, want.alpha);
    if (got.done !== want.done) report("image_done", got.done, want.done);
    if (got.visible !== want.visible) report("any_visible", got.visible, want.visible);
  endtask
endclass

module tb_alpha_over_compositor_unit;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 610;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;   // base_red .. base_opacity, over_red .. over_alpha
  logic        s_tlast;   // end_of_image
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // out_red, out_green, out_blue, out_alpha
  logic        m_tlast;   // image_done
  logic        m_tuser;   // any_visible

  composite_scoreboard sb;
  int tx_idle;
  int rx_idle;
  bit hold_req;
  int sent;
  int cycles;

  alpha_over_compositor_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, sb.expected_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Both handshakes sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_request(pixel_pair_t'(s_tdata), s_tlast);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast, m_tuser);
    end
  end

  // Output side: random back-pressure, or a long hold-off when asked
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        m_tready <= (rst == 1'b0) && ($urandom_range(99) >= rx_idle);
        @(negedge clk);
      end
    end
  end

  // Offer one request, idling at random first, and wait until it is taken
  task send_pixel(pixel_pair_t p, logic last);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= p;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sent++;
  endtask

  // Sender pause until every pending composite has come out
  task drain;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
  endtask

  function pixel_pair_t pair(logic [7:0] br, logic [7:0] bg, logic [7:0] bb, logic [7:0] ba,
                             logic [7:0] orr, logic [7:0] og, logic [7:0] ob,
                             logic [7:0] oa);
    return {oa, ob, og, orr, ba, bb, bg, br};
  endfunction

  // Alphas lean toward the edges of the range
  function logic [7:0] pick_alpha();
    case ($urandom_range(0, 6))
      0, 1: return 8'd0;
      2:    return 8'd255;
      3:    return 8'd1;
      4:    return 8'd254;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function logic [7:0] pick_color();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // style 0: all transparent, 1: mostly transparent, 2: anything goes
  function pixel_pair_t random_pair(int style);
    pixel_pair_t p;
    p = pair(pick_color(), pick_color(), pick_color(), pick_alpha(),
             pick_color(), pick_color(), pick_color(), pick_alpha());
    if (style == 0 || (style == 1 && $urandom_range(0, 5) != 0)) begin
      p.base_opacity = 8'd0;
      p.over_alpha   = 8'd0;
    end
    return p;
  endfunction

  task send_image();
    int len;
    int style;
    int pick;
    len  = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 16);
    pick = $urandom_range(0, 9);
    style = (pick == 0) ? 0 : (pick <= 2) ? 1 : 2;
    for (int i = 0; i < len; i++) send_pixel(random_pair(style), i == len - 1);
  endtask

  // One random phase, with an optional long output stall in the middle
  task run_phase(int tx_pct, int rx_pct, bit with_hold);
    int stop_at;
    bit held;
    tx_idle = tx_pct;
    rx_idle = rx_pct;
    stop_at = sent + PHASE_ITEMS;
    held = 1'b0;
    while (sent < stop_at) begin
      if (with_hold && !held && sent > stop_at - PHASE_ITEMS / 2) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      send_image();
    end
    drain();
  endtask

  initial begin
    sb       = new;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    tx_idle  = 32;
    rx_idle  = 57;
    hold_req = 1'b0;
    sent     = 0;
    cycles   = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: transparent pairs, opaque extremes, tiny alphas, bit patterns
    send_pixel(pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0);
    send_pixel(pair(8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0), 1'b1);
    send_pixel(pair(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255), 1'b1);
    send_pixel(pair(8'h55, 8'h55, 8'h55, 8'd255, 8'hAA, 8'hAA, 8'hAA, 8'd255), 1'b0);
    send_pixel(pair(8'h55, 8'hAA, 8'h55, 8'd255, 8'hAA, 8'h55, 8'hAA, 8'd0), 1'b0);
    send_pixel(pair(8'd200, 8'd10, 8'd90, 8'd128, 8'd30, 8'd240, 8'd77, 8'd128), 1'b0);
    send_pixel(pair(8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd128, 8'd1, 8'd1), 1'b0);
    send_pixel(pair(8'd255, 8'd128, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0), 1'b0);
    send_pixel(pair(8'd255, 8'd255, 8'd255, 8'd1, 8'd0, 8'd0, 8'd0, 8'd1), 1'b0);
    send_pixel(pair(8'd3, 8'd252, 8'd127, 8'd254, 8'd250, 8'd5, 8'd128, 8'd254), 1'b0);
    send_pixel(pair(8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55, 8'hAA), 1'b1);
    // one-pixel image with nothing visible
    send_pixel(pair(8'd9, 8'd99, 8'd199, 8'd0, 8'd17, 8'd171, 8'd71, 8'd0), 1'b1);
    // visible pixel early, transparent last pixel
    send_pixel(pair(8'd40, 8'd50, 8'd60, 8'd0, 8'd70, 8'd80, 8'd90, 8'd2), 1'b0);
    send_pixel(pair(8'd1, 8'd2, 8'd3, 8'd0, 8'd4, 8'd5, 8'd6, 8'd0), 1'b1);
    send_pixel(pair(8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255), 1'b0);
    send_pixel(pair(8'd100, 8'd150, 8'd250, 8'd200, 8'd11, 8'd22, 8'd33, 8'd127), 1'b1);
    drain();

    run_phase(32, 57, 1'b1);
    run_phase(57, 32, 1'b1);
    run_phase(0, 0, 1'b0);

    repeat (30) @(negedge clk);
    $display("Composited %0d pixel pairs in %0d images: %0d fully transparent pairs,",
             sb.pixels, sb.images, sb.transparent);
    $display("%0d images with nothing visible; mixed, swapped and no idling, two long stalls.",
             sb.dark_images);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
